>>> rtl/mqsb_pkg.sv
package mqsb_pkg;

    // Result status codes
    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_EMPTY = 2'd1;
    localparam logic [1:0] STS_FULL  = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clr_en;   // write one link of the clearing pass
        logic load_en;  // capture a request and start the first lookup
        logic look_en;  // decide the request, issue the dependent read
        logic fin_en;   // commit the update and load the result register
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clr_last; // clearing pass is at its final slot
    } dp_sts_t;

endpackage

>>> rtl/mqsb_ctrl.sv
module mqsb_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  mqsb_pkg::dp_sts_t sts,
    output mqsb_pkg::dp_cmd_t cmd
);
    import mqsb_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR  = 4'b0001,
        S_IDLE   = 4'b0010,
        S_LOOK   = 4'b0100,
        S_COMMIT = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    // Result register can take a new result when empty or draining
    assign out_free = !m_valid_reg || m_ready;

    // Clear the store after reset, then sequence one request through lookup and commit
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_en = 1'b1;
                if (sts.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_en = 1'b1;
                    state_next  = S_LOOK;
                end
            end
            S_LOOK: begin
                cmd.look_en = 1'b1;
                state_next  = S_COMMIT;
            end
            S_COMMIT: begin
                if (out_free) begin
                    cmd.fin_en = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // Hold the result valid until its transfer
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.fin_en) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

`ifndef SYNTH
    // A stalled commit waits in place
    a_commit_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_COMMIT && m_valid_reg && !m_ready) |=> (state_reg == S_COMMIT))
        else $error("commit left while result register was blocked");

    // Every commit presents a result
    a_commit_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fin_en |=> m_valid_reg)
        else $error("commit without a result");
`endif

endmodule

>>> rtl/mqsb_dpath.sv
module mqsb_dpath #(
    parameter int SLOT_COUNT,
    parameter int QUEUE_COUNT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  mqsb_pkg::dp_cmd_t   cmd,
    output mqsb_pkg::dp_sts_t   sts,
    input  logic                s_req_type,
    input  logic [2:0]          s_queue_index,
    input  logic signed [31:0]  s_data_in,
    output logic signed [31:0]  m_data_out,
    output logic [1:0]          m_status
);
    import mqsb_pkg::*;

    localparam int PTR_W  = $clog2(SLOT_COUNT + 1);
    localparam int SIDX_W = $clog2(SLOT_COUNT);
    localparam int QIDX_W = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
    localparam logic [PTR_W-1:0]  NULL_PTR  = PTR_W'(SLOT_COUNT);
    localparam logic [SIDX_W-1:0] LAST_SLOT = SIDX_W'(SLOT_COUNT - 1);

    // Slot store, link table and per-queue pointers
    logic signed [31:0] value_mem [SLOT_COUNT];
    logic [PTR_W-1:0]   link_mem  [SLOT_COUNT];
    logic [PTR_W-1:0]   head_mem  [QUEUE_COUNT];
    logic [PTR_W-1:0]   tail_mem  [QUEUE_COUNT];
    logic [QUEUE_COUNT-1:0] head_valid_reg;

    logic [PTR_W-1:0]   free_head_reg;
    logic [SIDX_W-1:0]  clr_cnt_reg;

    // Captured request
    logic               req_deq_reg;
    logic               q_ok_reg;
    logic [QIDX_W-1:0]  q_reg;
    logic signed [31:0] data_reg;

    // Registered read data and decisions
    logic [PTR_W-1:0]   head_rd_reg;
    logic [PTR_W-1:0]   tail_rd_reg;
    logic               hvalid_rd_reg;
    logic [PTR_W-1:0]   link_rd_reg;
    logic signed [31:0] val_rd_reg;
    logic               enq_go_reg;
    logic               deq_go_reg;
    logic               head_empty_reg;

    logic signed [31:0] data_out_reg;
    logic [1:0]         status_reg;

    logic               q_in_range;
    logic [QIDX_W-1:0]  qidx_in;
    logic               head_empty;
    logic               enq_go;
    logic               deq_go;
    logic [PTR_W-1:0]   link_norm;
    logic [PTR_W-1:0]   clr_data;
    logic               lnk_we;
    logic [SIDX_W-1:0]  lnk_waddr;
    logic [PTR_W-1:0]   lnk_wdata;
    logic               lnk_re;
    logic [SIDX_W-1:0]  lnk_raddr;

    function automatic logic is_slot(input logic [PTR_W-1:0] p);
        return p < NULL_PTR;
    endfunction

    // Decode the addressed queue
    assign q_in_range = {29'd0, s_queue_index} < 32'(QUEUE_COUNT);
    assign qidx_in    = q_in_range ? QIDX_W'(s_queue_index) : '0;

    // Decide the request from the first lookup
    assign head_empty = !hvalid_rd_reg || !is_slot(head_rd_reg);
    assign enq_go     = !req_deq_reg && q_ok_reg && is_slot(free_head_reg);
    assign deq_go     = req_deq_reg && q_ok_reg && !head_empty;
    assign link_norm  = is_slot(link_rd_reg) ? link_rd_reg : NULL_PTR;

    // Clearing pass rebuilds the initial free chain
    assign clr_data      = (clr_cnt_reg == LAST_SLOT) ? NULL_PTR
                                                      : PTR_W'(clr_cnt_reg) + PTR_W'(1);
    assign sts.clr_last  = (clr_cnt_reg == LAST_SLOT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr_en) begin
            clr_cnt_reg <= clr_cnt_reg + SIDX_W'(1);
        end
    end

    // Select the single link write of this cycle
    always_comb begin
        lnk_we    = 1'b0;
        lnk_waddr = '0;
        lnk_wdata = '0;
        if (cmd.clr_en) begin
            lnk_we    = 1'b1;
            lnk_waddr = clr_cnt_reg;
            lnk_wdata = clr_data;
        end else if (cmd.look_en && enq_go && !head_empty && is_slot(tail_rd_reg)) begin
            lnk_we    = 1'b1;
            lnk_waddr = tail_rd_reg[SIDX_W-1:0];
            lnk_wdata = free_head_reg;
        end else if (cmd.fin_en && enq_go_reg) begin
            lnk_we    = 1'b1;
            lnk_waddr = free_head_reg[SIDX_W-1:0];
            lnk_wdata = NULL_PTR;
        end else if (cmd.fin_en && deq_go_reg) begin
            lnk_we    = 1'b1;
            lnk_waddr = head_rd_reg[SIDX_W-1:0];
            lnk_wdata = free_head_reg;
        end
    end

    // Link read: free head's successor on accept, head's successor on dequeue
    assign lnk_re    = cmd.load_en || (cmd.look_en && deq_go);
    assign lnk_raddr = cmd.load_en ? free_head_reg[SIDX_W-1:0] : head_rd_reg[SIDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (lnk_we) begin
            link_mem[lnk_waddr] <= lnk_wdata;
        end
        if (lnk_re) begin
            link_rd_reg <= link_mem[lnk_raddr];
        end
    end

    // Value store
    always_ff @(posedge aclk) begin
        if (cmd.fin_en && enq_go_reg) begin
            value_mem[free_head_reg[SIDX_W-1:0]] <= data_reg;
        end
        if (cmd.look_en && deq_go) begin
            val_rd_reg <= value_mem[head_rd_reg[SIDX_W-1:0]];
        end
    end

    // Head and tail pointer stores
    always_ff @(posedge aclk) begin
        if (cmd.fin_en && enq_go_reg && head_empty_reg) begin
            head_mem[q_reg] <= free_head_reg;
        end else if (cmd.fin_en && deq_go_reg) begin
            head_mem[q_reg] <= link_norm;
        end
        if (cmd.fin_en && enq_go_reg) begin
            tail_mem[q_reg] <= free_head_reg;
        end
        if (cmd.load_en) begin
            head_rd_reg <= head_mem[qidx_in];
            tail_rd_reg <= tail_mem[qidx_in];
        end
    end

    // Capture the request and the lookup decisions
    always_ff @(posedge aclk) begin
        if (cmd.load_en) begin
            req_deq_reg <= s_req_type;
            q_ok_reg    <= q_in_range;
            q_reg       <= qidx_in;
            data_reg    <= s_data_in;
        end
        if (cmd.look_en) begin
            enq_go_reg     <= enq_go;
            deq_go_reg     <= deq_go;
            head_empty_reg <= head_empty;
        end
    end

    // Head valid bits and free list head
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= '0;
            free_head_reg  <= '0;
            hvalid_rd_reg  <= 1'b0;
        end else begin
            if (cmd.load_en) begin
                hvalid_rd_reg <= head_valid_reg[qidx_in];
            end
            if (cmd.fin_en && enq_go_reg) begin
                head_valid_reg[q_reg] <= 1'b1;
                free_head_reg         <= link_norm;
            end else if (cmd.fin_en && deq_go_reg) begin
                free_head_reg <= head_rd_reg;
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.fin_en) begin
            if (deq_go_reg) begin
                data_out_reg <= val_rd_reg;
                status_reg   <= STS_OK;
            end else if (enq_go_reg) begin
                data_out_reg <= '0;
                status_reg   <= STS_OK;
            end else begin
                data_out_reg <= '0;
                status_reg   <= req_deq_reg ? STS_EMPTY : STS_FULL;
            end
        end
    end

    assign m_data_out = data_out_reg;
    assign m_status   = status_reg;

`ifndef SYNTH
    // An enqueue commits only into a real free slot
    a_alloc_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.fin_en && enq_go_reg) |-> is_slot(free_head_reg))
        else $error("enqueue committed without a free slot");

    // A committed enqueue leaves its queue with a valid head
    a_head_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.fin_en && enq_go_reg) |=> head_valid_reg[$past(q_reg)])
        else $error("queue head not valid after enqueue");
`endif

endmodule

>>> rtl/multi_queue_shared_buffer.sv
// Shared-store multi-queue: QUEUE_COUNT FIFO queues live in one store of
// SLOT_COUNT slots, chained through a link table, with unused slots kept on
// a free list. Each request enqueues a value into, or dequeues the head value
// from, the addressed queue and yields exactly one result carrying data_out
// and a status (ok, queue empty, store full); an out-of-range queue number is
// refused as empty on dequeue and full on enqueue. A request passes through
// accept with the head, tail and free-slot link lookup, then a decision
// step that issues the dependent read of the link and value stores (or
// links the new slot after the tail), and then a commit step. The next
// request is accepted while a result still waits in the output register;
// commit waits only when that register is still full. After reset a
// clearing pass over all SLOT_COUNT slots rebuilds the free chain before
// the first request is accepted.
module multi_queue_shared_buffer #(
    parameter int SLOT_COUNT  = 16,
    parameter int QUEUE_COUNT = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_req_type,
    input  logic [2:0]         s_queue_index,
    input  logic signed [31:0] s_data_in,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_data_out,
    output logic [1:0]         m_status
);
    import mqsb_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    mqsb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    mqsb_dpath #(
        .SLOT_COUNT  (SLOT_COUNT),
        .QUEUE_COUNT (QUEUE_COUNT)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_req_type    (s_req_type),
        .s_queue_index (s_queue_index),
        .s_data_in     (s_data_in),
        .m_data_out    (m_data_out),
        .m_status      (m_status)
    );

endmodule
